[sv/mrc_pkg.sv]
package mrc_pkg;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned ACC_W   = 32;
   localparam int unsigned SUM_W   = 21;
   localparam int unsigned POS_W   = 3;

   localparam logic [ACC_W-1:0] MAG_MASK = 32'h000f_ffff;

   // configuration register indexes
   localparam logic CSR_VERTEX_TOTAL  = 1'b0;
   localparam logic CSR_POLYGON_TOTAL = 1'b1;

   // vertex record layout
   localparam logic [POS_W-1:0] VERT_TEX_POS  = 3'd6;
   localparam logic [POS_W-1:0] VERT_LAST_POS = 3'd7;

   // polygon record layout
   localparam logic [POS_W-1:0] POLY_TAG_POS   = 3'd0;
   localparam logic [POS_W-1:0] POLY_COUNT_POS = 3'd1;
   localparam logic [POS_W-1:0] POLY_INDEX_POS = 3'd2;

   localparam logic [WORD_W-1:0] SHORT_FACE  = 16'd4;
   localparam logic [WORD_W-1:0] MEDIUM_FACE = 16'd7;

   typedef enum logic [1:0] {
      SEC_IDLE = 2'd0,
      SEC_VERT = 2'd1,
      SEC_POLY = 2'd2
   } section_type;

   typedef struct packed {
      logic [ACC_W-1:0]  accumulator;
      logic [WORD_W-1:0] records_left;
      section_type       section;
      logic [POS_W-1:0]  word_position;
      logic [WORD_W-1:0] index_words_left;
   } walk_state_type;

   localparam walk_state_type WALK_IDLE = '{
      accumulator:      '0,
      records_left:     '0,
      section:          SEC_IDLE,
      word_position:    '0,
      index_words_left: '0
   };

   // sign-magnitude fold to 20 bits: magnitude mod 2^20, sign kept
   function automatic logic [ACC_W-1:0] reduce20(input logic [ACC_W-1:0] v);
      logic [ACC_W-1:0] mag;
      begin
         mag = (ACC_W'(0) - v) & MAG_MASK;
         if (v[ACC_W-1] == 1'b0) begin
            reduce20 = v & MAG_MASK;
         end else begin
            reduce20 = ACC_W'(0) - mag;
         end
      end
   endfunction

endpackage

[sv/mesh_record_checksum_top.sv]
// Latency: an item's checksum, when it completes the body, is valid the cycle after acceptance.
// Throughput: one item per cycle while req_ready is high; one registered walk step per word.
// req_ready stays high while the output register is empty or being drained.
// Reset (synchronous, active high) clears both registers, the walk state and
// the output valid; the block comes out idle, waiting for a start item.
module mesh_record_checksum_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [mrc_pkg::WORD_W-1:0]        csr_wdata,
   // body word stream
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mrc_pkg::WORD_W-1:0]        req_body_word,
   input  logic                              req_start_req,
   // checksum result
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [mrc_pkg::SUM_W-1:0]  rsp_checksum
);
   import mrc_pkg::*;

   // configuration registers
   logic [WORD_W-1:0] vertex_total_ff;
   logic [WORD_W-1:0] polygon_total_ff;

   // walk state: accumulator, record and word counters, section
   walk_state_type walk_ff;
   walk_state_type walk_in;

   // output register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [SUM_W-1:0] checksum_ff;
   logic signed [SUM_W-1:0] checksum_in;

   logic                    req_take;
   logic                    step_emit;
   logic signed [SUM_W-1:0] step_sum;
   walk_state_type          step_nxt;

   // The output register decouples the sides: a new item goes in whenever the
   // held checksum is absent or leaves this same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   mrc_step u_step (
      .cur           (walk_ff),
      .body_word     (req_body_word),
      .start_req     (req_start_req),
      .vertex_total  (vertex_total_ff),
      .polygon_total (polygon_total_ff),
      .nxt           (step_nxt),
      .emit          (step_emit),
      .checksum      (step_sum)
   );

   always_comb begin
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      checksum_in  = checksum_ff;
      if (req_take) begin
         walk_in = step_nxt;
         if (step_emit) begin
            rsp_valid_in = 1'b1;
            checksum_in  = step_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_total_ff  <= '0;
         polygon_total_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_TOTAL:  vertex_total_ff  <= csr_wdata;
            CSR_POLYGON_TOTAL: polygon_total_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= WALK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      checksum_ff <= checksum_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = checksum_ff;

endmodule

[sv/mrc_step.sv]
module mrc_step (
   input  mrc_pkg::walk_state_type       cur,
   input  logic [mrc_pkg::WORD_W-1:0]    body_word,
   input  logic                          start_req,
   input  logic [mrc_pkg::WORD_W-1:0]    vertex_total,
   input  logic [mrc_pkg::WORD_W-1:0]    polygon_total,
   output mrc_pkg::walk_state_type       nxt,
   output logic                          emit,
   output logic signed [mrc_pkg::SUM_W-1:0] checksum
);
   import mrc_pkg::*;

   walk_state_type   base;
   logic [ACC_W-1:0] addend;
   logic [ACC_W-1:0] sum;
   logic [ACC_W-1:0] folded;
   logic [WORD_W-1:0] recs_dec;
   logic [WORD_W-1:0] idx_dec;
   logic             rec_done;

   always_comb begin
      // start_req reloads the walk before the word itself is counted
      base = cur;
      if (start_req) begin
         base.accumulator      = '0;
         base.word_position    = '0;
         base.index_words_left = '0;
         if (vertex_total != '0) begin
            base.section      = SEC_VERT;
            base.records_left = vertex_total;
         end else if (polygon_total != '0) begin
            base.section      = SEC_POLY;
            base.records_left = polygon_total;
         end else begin
            base = WALK_IDLE;
         end
      end
   end

   always_comb begin
      addend = {{(ACC_W-WORD_W){1'b0}}, body_word};
      if (base.section == SEC_VERT) begin
         if (base.word_position >= VERT_TEX_POS) begin
            addend = {{(ACC_W-WORD_W){body_word[WORD_W-1]}}, body_word};
         end else if (base.word_position[0]) begin
            addend = {body_word, {(ACC_W-WORD_W){1'b0}}};
         end
      end
   end

   assign sum      = base.accumulator + addend;
   assign folded   = reduce20(sum);
   assign recs_dec = base.records_left - WORD_W'(1);
   assign idx_dec  = base.index_words_left - WORD_W'(1);

   always_comb begin
      nxt      = base;
      emit     = 1'b0;
      checksum = '0;
      rec_done = 1'b0;

      if (start_req && base.section == SEC_IDLE) begin
         // empty body: zero checksum right away, word dropped
         emit = 1'b1;
      end else begin
         case (base.section)
            SEC_VERT: begin
               nxt.accumulator = sum;
               if (base.word_position == VERT_LAST_POS) begin
                  rec_done = 1'b1;
               end else begin
                  nxt.word_position = base.word_position + POS_W'(1);
               end
            end
            SEC_POLY: begin
               nxt.accumulator = sum;
               if (base.word_position == POLY_TAG_POS) begin
                  nxt.word_position = POLY_COUNT_POS;
               end else if (base.word_position == POLY_COUNT_POS) begin
                  if (body_word <= SHORT_FACE) begin
                     nxt.index_words_left = SHORT_FACE;
                  end else if (body_word <= MEDIUM_FACE) begin
                     nxt.index_words_left = MEDIUM_FACE;
                  end else begin
                     nxt.index_words_left = body_word;
                  end
                  nxt.word_position = POLY_INDEX_POS;
               end else begin
                  nxt.index_words_left = idx_dec;
                  rec_done = (idx_dec == '0);
               end
            end
            default: begin
               nxt = base;
            end
         endcase

         if (rec_done) begin
            nxt.accumulator      = folded;
            nxt.word_position    = '0;
            nxt.index_words_left = '0;
            nxt.records_left     = recs_dec;
            if (recs_dec == '0) begin
               if (base.section == SEC_VERT && polygon_total != '0) begin
                  nxt.section      = SEC_POLY;
                  nxt.records_left = polygon_total;
               end else begin
                  emit     = 1'b1;
                  checksum = folded[SUM_W-1:0];
                  nxt      = WALK_IDLE;
                  nxt.accumulator = folded;
               end
            end
         end
      end
   end

endmodule
